// ===== design/tss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Three stacks in one array: shared package
// Sizes, pointer types, command and status codes, queue entry and state
// machine types, and small helper functions used by the back end.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Memory geometry: three segments of SEG words each.
  localparam int SEG    = 8;
  localparam int WORDS  = 3 * SEG;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(WORDS);
  // Signed stack pointers must hold -1 up to WORDS + 1.
  localparam int PTR_W  = $clog2(WORDS + 2) + 1;
  // Intermediate sums of two pointers need headroom.
  localparam int SUM_W  = PTR_W + 2;
  // Copy length counter holds up to WORDS.
  localparam int CNT_W  = $clog2(WORDS + 1);

  // Command queue between the front and the back end.
  localparam int Q_DEPTH = 2;
  localparam int QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef logic signed [PTR_W-1:0] ptr_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Reset values of the stack pointers.
  localparam ptr_t LOWER_TOP_RST     = ptr_t'(-1);
  localparam ptr_t UPPER_TOP_RST     = ptr_t'(WORDS);
  localparam ptr_t MIDDLE_TOP_RST    = ptr_t'(SEG - 1);
  localparam ptr_t MIDDLE_BOTTOM_RST = ptr_t'(SEG);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STK_LOWER  = 2'd0,
    STK_UPPER  = 2'd1,
    STK_MIDDLE = 2'd2
  } stack_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Class of an accepted item, decided by the front end.
  typedef enum logic [1:0] {
    K_NOP  = 2'd0,
    K_PUSH = 2'd1,
    K_POP  = 2'd2,
    K_PEEK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_COPY  = 2'd2,
    BK_WRITE = 2'd3
  } bk_state_t;

  typedef struct packed {
    kind_t              kind;
    stack_t             sel;
    logic [DATA_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Halve a signed sum, rounding toward zero.
  function automatic sum_t half_trunc(input sum_t s);
    sum_t adj;
    adj = s + sum_t'(s[SUM_W-1]);
    return adj >>> 1;
  endfunction

  // True when a pointer names a word of the memory.
  function automatic logic in_range(input ptr_t p);
    return (p >= ptr_t'(0)) && (p < ptr_t'(WORDS));
  endfunction

endpackage : tss_pkg
`default_nettype wire

// ===== design/tss_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule : tss_ram
`default_nettype wire

// ===== design/tss_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Three stacks in one array: front end
// Accepts commands, sorts them into push, pop, peek or no-op, and hands
// them to the command queue.
// ----------------------------------------------------------------------------
module tss_front
  import tss_pkg::*;
(
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_command,
  input  wire logic [1:0]         in_stack_select,
  input  wire logic [DATA_W-1:0]  in_push_value,
  input  wire q_stat_t            q_stat,
  output logic                    q_push,
  output item_t                   q_item
);

  logic  cmd_ok;
  logic  sel_ok;
  kind_t kind;

  // The front end holds off new commands while the queue is full.
  assign busy   = q_stat.full;
  assign q_push = start && !q_stat.full;

  // Unknown commands or selectors become no-ops with an OK result.
  always_comb begin
    cmd_ok = in_command inside {CMD_PUSH, CMD_POP, CMD_PEEK};
    sel_ok = in_stack_select inside {STK_LOWER, STK_UPPER, STK_MIDDLE};
    kind   = K_NOP;
    if (cmd_ok && sel_ok) begin
      case (in_command)
        CMD_PUSH: kind = K_PUSH;
        CMD_POP:  kind = K_POP;
        CMD_PEEK: kind = K_PEEK;
        default:  kind = K_NOP;
      endcase
    end
  end

  assign q_item = '{kind: kind, sel: stack_t'(in_stack_select), value: in_push_value};

endmodule : tss_front
`default_nettype wire

// ===== design/tss_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Three stacks in one array: command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tss_queue
  import tss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire item_t   push_item,
  input  wire logic    pop,
  output item_t        head,
  output q_stat_t      stat
);

  item_t            slots_r [Q_DEPTH];
  logic [QA_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  count_r, count_nxt;

  // Pointer and fill count updates; both ends may move in one cycle.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QA_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QA_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QA_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  assign head       = slots_r[rd_ptr_r];
  assign stat.full  = (count_r == QC_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule : tss_queue
`default_nettype wire

// ===== design/tss_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Three stacks in one array: back end
// Keeps the stack pointers, plans each command, relocates the middle stack
// one word per cycle when a push collides, and produces the results.
// ----------------------------------------------------------------------------
module tss_back
  import tss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire item_t              q_head,
  input  wire q_stat_t            q_stat,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic [DATA_W-1:0]       out_read_value,
  output logic [1:0]              out_status
);

  // State and pointer registers.
  bk_state_t          state_r, state_nxt;
  ptr_t               lt_r, lt_nxt;
  ptr_t               ut_r, ut_nxt;
  ptr_t               mt_r, mt_nxt;
  ptr_t               mb_r, mb_nxt;

  // Relocation and pending push registers.
  ptr_t               src_r, src_nxt;
  ptr_t               delta_r, delta_nxt;
  logic               down_r, down_nxt;
  logic [CNT_W-1:0]   rd_left_r, rd_left_nxt;
  logic               pend_r, pend_nxt;
  ptr_t               pend_addr_r, pend_addr_nxt;
  ptr_t               push_addr_r, push_addr_nxt;
  logic [DATA_W-1:0]  push_val_r, push_val_nxt;

  // Result registers.
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_value_r, out_value_nxt;
  status_t            out_status_r, out_status_nxt;

  // Memory port.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  // Plan signals.
  sum_t               lt_s, ut_s, mt_s, mb_s;
  sum_t               used;
  logic               is_full;
  sum_t               new_lt, new_ut;
  logic               coll;
  sum_t               gap_c, mid_c, d0, shift;
  sum_t               new_mt, new_mb, fin_mt, wr_ptr;
  logic               need_copy;
  ptr_t               copy_src;
  logic [CNT_W-1:0]   copy_len;
  logic               is_empty;
  ptr_t               top_ptr;

  tss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Plan the queue head against the current pointers.
  always_comb begin
    lt_s = sum_t'(lt_r);
    ut_s = sum_t'(ut_r);
    mt_s = sum_t'(mt_r);
    mb_s = sum_t'(mb_r);

    used = (lt_s + sum_t'(1)) + (sum_t'(WORDS) - ut_s) + (mt_s - mb_s + sum_t'(1));
    is_full = (used >= sum_t'(WORDS));

    // Push: advance the selected top and detect a collision.
    new_lt = lt_s;
    new_ut = ut_s;
    coll   = 1'b0;
    case (q_head.sel)
      STK_LOWER: begin
        new_lt = lt_s + sum_t'(1);
        coll   = (new_lt == mb_s);
      end
      STK_UPPER: begin
        new_ut = ut_s - sum_t'(1);
        coll   = (new_ut == mt_s);
      end
      STK_MIDDLE: begin
        coll = (mt_s + sum_t'(1) == ut_s);
      end
      default: coll = 1'b0;
    endcase

    // Recenter the middle stack in the gap between the other two.
    gap_c = half_trunc(new_lt + new_ut);
    mid_c = half_trunc(mb_s + mt_s);
    d0    = gap_c - mid_c;
    shift = '0;
    if (coll) begin
      shift = d0;
      // A middle push that still abuts the upper stack moves one more word down.
      if ((q_head.sel == STK_MIDDLE) && (mt_s + d0 + sum_t'(1) == ut_s)) begin
        shift = d0 - sum_t'(1);
      end
    end
    new_mt = mt_s + shift;
    new_mb = mb_s + shift;
    fin_mt = new_mt;
    case (q_head.sel)
      STK_LOWER:  wr_ptr = new_lt;
      STK_UPPER:  wr_ptr = new_ut;
      STK_MIDDLE: begin
        wr_ptr = new_mt + sum_t'(1);
        fin_mt = new_mt + sum_t'(1);
      end
      default:    wr_ptr = new_lt;
    endcase

    // A downward move copies from the bottom, an upward one from the top.
    need_copy = (shift != '0) && (mt_s >= mb_s);
    copy_src  = (shift < 0) ? mb_r : mt_r;
    copy_len  = CNT_W'(mt_s - mb_s + sum_t'(1));

    // Pop and peek: empty test and top word address.
    case (q_head.sel)
      STK_LOWER: begin
        is_empty = (lt_r == LOWER_TOP_RST);
        top_ptr  = lt_r;
      end
      STK_UPPER: begin
        is_empty = (ut_r == UPPER_TOP_RST);
        top_ptr  = ut_r;
      end
      STK_MIDDLE: begin
        is_empty = (mt_s == mb_s - sum_t'(1));
        top_ptr  = mt_r;
      end
      default: begin
        is_empty = 1'b1;
        top_ptr  = lt_r;
      end
    endcase
  end

  // Sequencer: next state, pointer updates and memory accesses.
  always_comb begin
    state_nxt      = state_r;
    lt_nxt         = lt_r;
    ut_nxt         = ut_r;
    mt_nxt         = mt_r;
    mb_nxt         = mb_r;
    src_nxt        = src_r;
    delta_nxt      = delta_r;
    down_nxt       = down_r;
    rd_left_nxt    = rd_left_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    push_addr_nxt  = push_addr_r;
    push_val_nxt   = push_val_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = push_val_r;
    ram_raddr      = '0;

    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop          = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = ST_OK;
          case (q_head.kind)
            K_PUSH: begin
              if (is_full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else begin
                lt_nxt        = ptr_t'(new_lt);
                ut_nxt        = ptr_t'(new_ut);
                mt_nxt        = ptr_t'(fin_mt);
                mb_nxt        = ptr_t'(new_mb);
                push_addr_nxt = ptr_t'(wr_ptr);
                push_val_nxt  = q_head.value;
                src_nxt       = copy_src;
                delta_nxt     = ptr_t'(shift);
                down_nxt      = (shift > 0);
                rd_left_nxt   = copy_len;
                pend_nxt      = 1'b0;
                state_nxt     = need_copy ? BK_COPY : BK_WRITE;
              end
            end
            K_POP, K_PEEK: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_raddr = top_ptr[ADDR_W-1:0];
                if (q_head.kind == K_POP) begin
                  case (q_head.sel)
                    STK_LOWER:  lt_nxt = lt_r - ptr_t'(1);
                    STK_UPPER:  ut_nxt = ut_r + ptr_t'(1);
                    STK_MIDDLE: mt_nxt = mt_r - ptr_t'(1);
                    default:    lt_nxt = lt_r;
                  endcase
                end
                state_nxt = BK_READ;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      BK_READ: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = ram_rdata;
        out_status_nxt = ST_OK;
        state_nxt      = BK_IDLE;
      end

      BK_COPY: begin
        // Read one word ahead while the previous one is written back.
        if (pend_r) begin
          ram_we    = in_range(pend_addr_r);
          ram_waddr = pend_addr_r[ADDR_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (rd_left_r != '0) begin
          ram_raddr     = src_r[ADDR_W-1:0];
          src_nxt       = down_r ? src_r - ptr_t'(1) : src_r + ptr_t'(1);
          rd_left_nxt   = rd_left_r - CNT_W'(1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = src_r + delta_r;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = BK_WRITE;
        end
      end

      BK_WRITE: begin
        ram_we         = in_range(push_addr_r);
        ram_waddr      = push_addr_r[ADDR_W-1:0];
        ram_wdata      = push_val_r;
        out_valid_nxt  = 1'b1;
        out_value_nxt  = '0;
        out_status_nxt = ST_OK;
        state_nxt      = BK_IDLE;
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      lt_r        <= LOWER_TOP_RST;
      ut_r        <= UPPER_TOP_RST;
      mt_r        <= MIDDLE_TOP_RST;
      mb_r        <= MIDDLE_BOTTOM_RST;
      rd_left_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lt_r        <= lt_nxt;
      ut_r        <= ut_nxt;
      mt_r        <= mt_nxt;
      mb_r        <= mb_nxt;
      rd_left_r   <= rd_left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    delta_r      <= delta_nxt;
    down_r       <= down_nxt;
    pend_addr_r  <= pend_addr_nxt;
    push_addr_r  <= push_addr_nxt;
    push_val_r   <= push_val_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

endmodule : tss_back
`default_nettype wire

// ===== design/three_stacks_shared_array_core.sv =====
`default_nettype none
// A pop or peek passes through BK_READ, and a push through BK_WRITE, before its result
// strobe; an error or unknown command is answered from BK_IDLE. The back end takes one
// command at a time through the single memory port, and a push that moves the middle stack
// first copies its words in BK_COPY. Results cannot be stalled. Reset empties all three
// stacks and the command queue; memory contents stay undefined until written, with no
// clearing pass.
// ----------------------------------------------------------------------------
// Three stacks in one array: top level
// Front end, command queue and back end for three stacks sharing one memory.
// ----------------------------------------------------------------------------
module three_stacks_shared_array_core
  import tss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_command,
  input  wire logic [1:0]         in_stack_select,
  input  wire logic [DATA_W-1:0]  in_push_value,
  output logic                    out_valid,
  output logic [DATA_W-1:0]       out_read_value,
  output logic [1:0]              out_status
);

  q_stat_t q_stat;
  item_t   q_item;
  item_t   q_head;
  logic    q_push;
  logic    q_pop;

  // Command decode and accept.
  tss_front u_front (
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_stack_select (in_stack_select),
    .in_push_value   (in_push_value),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  // Queue between the two ends.
  tss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Stack engine.
  tss_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

endmodule : three_stacks_shared_array_core
`default_nettype wire

// ===== design/tss_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Three stacks in one array: port checker
// Watches the top level ports and checks results against accepted commands.
// ----------------------------------------------------------------------------
module tss_checker
  import tss_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [DATA_W-1:0]  out_read_value,
  input wire logic [1:0]         out_status
);

  logic [2:0] outstanding_r, outstanding_nxt;

  // Count commands transferred in but not yet answered.
  always_comb begin
    outstanding_nxt = outstanding_r;
    if ((start && !busy) && !out_valid) begin
      outstanding_nxt = outstanding_r + 3'd1;
    end else if (!(start && !busy) && out_valid) begin
      outstanding_nxt = outstanding_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  // Every result answers an earlier command.
  a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (outstanding_r != 3'd0))
    else $error("result without an outstanding command");

  // Status is always a defined code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL || out_status == ST_EMPTY))
    else $error("undefined status code");

  // Error results carry a zero word.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_read_value == '0))
    else $error("error result with nonzero word");

  // Busy only when the queue holds unanswered commands.
  a_busy_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (outstanding_r >= 3'(Q_DEPTH)))
    else $error("busy without a full backlog");

  // No result strobe right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule : tss_checker

bind three_stacks_shared_array_core tss_checker u_tss_checker (.*);
`default_nettype wire
